// ===== rtl/qxm_pkg.sv =====
// Shared constants, register codes and transfer types for the quad-X mixer and
// flight sequencer. Self-contained; imported by every module of the block.
package qxm_pkg;

    localparam logic [10:0] MIN_PULSE    = 11'd1000;
    localparam logic [10:0] MAX_PULSE    = 11'd2000;
    localparam logic [14:0] MIN_THROTTLE = 15'd16000;
    localparam logic [14:0] MAX_THROTTLE = 15'd32000;
    localparam logic [17:0] ELAPSED_MAX  = 18'h3FFFF;

    localparam logic [10:0] RST_BASE_THROTTLE    = 11'd1365;
    localparam logic [10:0] RST_CORRECTION_LIMIT = 11'd200;
    localparam logic [15:0] RST_FLIGHT_TICKS     = 16'd15000;
    localparam logic [15:0] RST_LANDING_TICKS    = 16'd3000;
    localparam logic [7:0]  RST_SEND_PERIOD      = 8'd20;

    localparam logic [2:0] REG_BASE_THROTTLE    = 3'd0;
    localparam logic [2:0] REG_CORRECTION_LIMIT = 3'd1;
    localparam logic [2:0] REG_FLIGHT_TICKS     = 3'd2;
    localparam logic [2:0] REG_LANDING_TICKS    = 3'd3;
    localparam logic [2:0] REG_SEND_PERIOD      = 3'd4;

    localparam logic [1:0] PH_FLIGHT   = 2'd0;
    localparam logic [1:0] PH_LANDING  = 2'd1;
    localparam logic [1:0] PH_DISARMED = 2'd2;

    localparam logic [3:0] MUL_LAST = 4'd15;
    localparam logic [3:0] DIV_LAST = 4'd13;

    typedef struct packed {
        logic [10:0] base_throttle;
        logic [10:0] correction_limit;
        logic [15:0] flight_ticks;
        logic [15:0] landing_ticks;
        logic [7:0]  send_period;
    } cfg_t;

    typedef struct packed {
        logic [14:0]        throttle;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic [1:0]         phase;
        logic               send;
    } mix_in_t;

endpackage

// ===== rtl/qxm_regs.sv =====
// APB configuration registers of the quad-X mixer and flight sequencer.
// Depends on qxm_pkg for register codes, reset values and cfg_t.
module qxm_regs import qxm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[4:2])
                REG_BASE_THROTTLE:    cfg_next.base_throttle    = pwdata[10:0];
                REG_CORRECTION_LIMIT: cfg_next.correction_limit = pwdata[10:0];
                REG_FLIGHT_TICKS:     cfg_next.flight_ticks     = pwdata[15:0];
                REG_LANDING_TICKS:    cfg_next.landing_ticks    = pwdata[15:0];
                REG_SEND_PERIOD:      cfg_next.send_period      = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_throttle    <= RST_BASE_THROTTLE;
            cfg_reg.correction_limit <= RST_CORRECTION_LIMIT;
            cfg_reg.flight_ticks     <= RST_FLIGHT_TICKS;
            cfg_reg.landing_ticks    <= RST_LANDING_TICKS;
            cfg_reg.send_period      <= RST_SEND_PERIOD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_BASE_THROTTLE:    prdata = {21'd0, cfg_reg.base_throttle};
            REG_CORRECTION_LIMIT: prdata = {21'd0, cfg_reg.correction_limit};
            REG_FLIGHT_TICKS:     prdata = {16'd0, cfg_reg.flight_ticks};
            REG_LANDING_TICKS:    prdata = {16'd0, cfg_reg.landing_ticks};
            REG_SEND_PERIOD:      prdata = {24'd0, cfg_reg.send_period};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/qxm_ramp.sv =====
// Bit-serial landing ramp unit: shift-add multiply, then restoring divide.
// Depends on qxm_pkg for the step counts.
module qxm_ramp import qxm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [13:0] diff,
    input  logic [15:0] le,
    input  logic [15:0] span,
    output logic        done,
    output logic [13:0] quot
);

    typedef enum logic [2:0] {
        R_IDLE = 3'b001,
        R_MUL  = 3'b010,
        R_DIV  = 3'b100
    } ramp_state_t;

    ramp_state_t state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [29:0] acc_reg, acc_next;
    logic [15:0] mplr_reg, mplr_next;
    logic [13:0] diff_reg, diff_next;
    logic [15:0] span_reg, span_next;
    logic [16:0] trial;
    logic [16:0] trial_sub;
    logic        ge;

    // The high part of the shift register holds the partial remainder and the
    // quotient bits enter at the bottom as the dividend bits leave.
    assign trial     = {acc_reg[29:14], acc_reg[13]};
    assign ge        = trial >= {1'b0, span_reg};
    assign trial_sub = trial - {1'b0, span_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        mplr_next  = mplr_reg;
        diff_next  = diff_reg;
        span_next  = span_reg;
        case (state_reg)
            R_IDLE: begin
                if (start) begin
                    acc_next   = 30'd0;
                    mplr_next  = le;
                    diff_next  = diff;
                    span_next  = span;
                    cnt_next   = 4'd0;
                    state_next = R_MUL;
                end
            end
            R_MUL: begin
                acc_next  = {acc_reg[28:0], 1'b0} + (mplr_reg[15] ? {16'd0, diff_reg} : 30'd0);
                mplr_next = {mplr_reg[14:0], 1'b0};
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == MUL_LAST) begin
                    cnt_next   = 4'd0;
                    state_next = R_DIV;
                end
            end
            R_DIV: begin
                acc_next = {(ge ? trial_sub[15:0] : trial[15:0]), acc_reg[12:0], ge};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST) begin
                    cnt_next   = 4'd0;
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
            end
            default: state_next = R_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            cnt_reg   <= 4'd0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        mplr_reg <= mplr_next;
        diff_reg <= diff_next;
        span_reg <= span_next;
    end

    assign done = done_reg;
    assign quot = acc_reg[13:0];

endmodule

// ===== rtl/qxm_mix.sv =====
// Quad-X motor mixer with pulse clamping and the result output register.
// Depends on qxm_pkg for pulse limits and mix_in_t.
module qxm_mix import qxm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  mix_in_t     mix_in,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [10:0] m_front_right_pulse,
    output logic [10:0] m_rear_right_pulse,
    output logic [10:0] m_front_left_pulse,
    output logic [10:0] m_rear_left_pulse,
    output logic [14:0] m_throttle_now,
    output logic [1:0]  m_phase,
    output logic        m_send_now
);

    function automatic logic [10:0] pulse_of(input logic signed [18:0] s);
        logic [14:0] c;
        if (s < $signed({4'd0, MIN_THROTTLE})) begin
            c = MIN_THROTTLE;
        end else if (s > $signed({4'd0, MAX_THROTTLE})) begin
            c = MAX_THROTTLE;
        end else begin
            c = s[14:0];
        end
        return c[14:4];
    endfunction

    logic signed [18:0] t_s, r_s, p_s, y_s;
    logic               m_valid_reg, m_valid_next;
    logic [10:0]        fr_reg, rr_reg, fl_reg, rl_reg;
    logic [14:0]        thr_reg;
    logic [1:0]         phase_reg;
    logic               send_reg;

    assign t_s = $signed({4'd0, mix_in.throttle});
    assign r_s = {{3{mix_in.roll[15]}}, mix_in.roll};
    assign p_s = {{3{mix_in.pitch[15]}}, mix_in.pitch};
    assign y_s = {{3{mix_in.yaw[15]}}, mix_in.yaw};

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            fr_reg    <= pulse_of(t_s - r_s - p_s + y_s);
            rr_reg    <= pulse_of(t_s - r_s + p_s - y_s);
            fl_reg    <= pulse_of(t_s + r_s - p_s - y_s);
            rl_reg    <= pulse_of(t_s + r_s + p_s + y_s);
            thr_reg   <= mix_in.throttle;
            phase_reg <= mix_in.phase;
            send_reg  <= mix_in.send;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_front_right_pulse = fr_reg;
    assign m_rear_right_pulse  = rr_reg;
    assign m_front_left_pulse  = fl_reg;
    assign m_rear_left_pulse   = rl_reg;
    assign m_throttle_now      = thr_reg;
    assign m_phase             = phase_reg;
    assign m_send_now          = send_reg;

endmodule

// ===== rtl/quad_x_mixer_flight_sequencer_core.sv =====
// Top level of the quad-X mixer and flight sequencer: timeline control.
// Depends on qxm_pkg, qxm_regs, qxm_ramp and qxm_mix.
//
//   Channel   Prefix  Handshake              Contents
//   input     s_      s_valid / s_ready      op and three axis corrections
//   result    m_      m_valid / m_ready      four pulses, throttle, phase, send
//   config    p       psel/penable/pready    five registers at 4*i
//
// A start transaction, a flight tick or a disarmed tick goes from ST_IDLE to ST_OUT.
// A landing tick also waits in ST_RAMP for the 16-step serial multiply and the
// 14-step restoring divide in the ramp unit.
// A new transaction is taken while the previous result waits in the output register.
// A stalled result holds the sequencer before its load until m_ready frees the register.
// Reset leaves the block disarmed with the register reset values and no result pending.
module quad_x_mixer_flight_sequencer_core import qxm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic signed [15:0] s_roll_correction,
    input  logic signed [15:0] s_pitch_correction,
    input  logic signed [15:0] s_yaw_correction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_front_right_pulse,
    output logic [10:0] m_rear_right_pulse,
    output logic [10:0] m_front_left_pulse,
    output logic [10:0] m_rear_left_pulse,
    output logic [14:0] m_throttle_now,
    output logic [1:0]  m_phase,
    output logic        m_send_now
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RAMP = 3'b010,
        ST_OUT  = 3'b100
    } seq_state_t;

    function automatic logic signed [15:0] clamp_corr(input logic signed [15:0] x,
                                                      input logic [14:0] lim);
        logic signed [16:0] xe;
        logic signed [16:0] hi;
        logic signed [16:0] lo;
        logic signed [15:0] res;
        xe  = {x[15], x};
        hi  = {2'b00, lim};
        lo  = -hi;
        res = x;
        if (xe > hi) begin
            res = hi[15:0];
        end else if (xe < lo) begin
            res = lo[15:0];
        end
        return res;
    endfunction

    cfg_t        cfg;
    seq_state_t  state_reg, state_next;
    logic [17:0] elapsed_reg, elapsed_next;
    logic        disarmed_reg, disarmed_next;
    logic [7:0]  send_cnt_reg, send_cnt_next;
    mix_in_t     item_reg, item_next;
    mix_in_t     mix_in;

    logic        accept;
    logic        load;
    logic        ramp_done;
    logic [13:0] ramp_quot;
    logic        ramp_start;
    logic [10:0] base_c;
    logic [14:0] base16;
    logic [13:0] diff;
    logic [17:0] e_inc;
    logic [16:0] end_tick;
    logic        disarm_now;
    logic        in_flight;
    logic [17:0] le_wide;
    logic [7:0]  period;
    logic [8:0]  cnt_inc;
    logic [14:0] lim16;

    qxm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign base_c = (cfg.base_throttle < MIN_PULSE) ? MIN_PULSE :
                    (cfg.base_throttle > MAX_PULSE) ? MAX_PULSE : cfg.base_throttle;
    assign base16 = {base_c, 4'd0};
    assign diff   = {base_c[9:0] - MIN_PULSE[9:0], 4'd0};
    assign lim16  = {cfg.correction_limit, 4'd0};

    assign e_inc      = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 18'd1;
    assign end_tick   = {1'b0, cfg.flight_ticks} + {1'b0, cfg.landing_ticks};
    assign disarm_now = disarmed_reg || (e_inc >= {1'b0, end_tick});
    assign in_flight  = e_inc < {2'd0, cfg.flight_ticks};
    assign le_wide    = e_inc - {2'd0, cfg.flight_ticks};
    assign period     = (cfg.send_period == 8'd0) ? 8'd1 : cfg.send_period;
    assign cnt_inc    = {1'b0, send_cnt_reg} + 9'd1;

    assign ramp_start = accept && !s_op && !disarm_now && !in_flight;

    qxm_ramp u_ramp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ramp_start),
        .diff    (diff),
        .le      (le_wide[15:0]),
        .span    (cfg.landing_ticks),
        .done    (ramp_done),
        .quot    (ramp_quot)
    );

    always_comb begin
        state_next    = state_reg;
        elapsed_next  = elapsed_reg;
        disarmed_next = disarmed_reg;
        send_cnt_next = send_cnt_reg;
        item_next     = item_reg;
        load          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    item_next.throttle = base16;
                    item_next.roll     = 16'sd0;
                    item_next.pitch    = 16'sd0;
                    item_next.yaw      = 16'sd0;
                    item_next.phase    = PH_FLIGHT;
                    item_next.send     = 1'b0;
                    state_next         = ST_OUT;
                    if (s_op) begin
                        elapsed_next  = 18'd0;
                        disarmed_next = 1'b0;
                        send_cnt_next = 8'd0;
                    end else begin
                        elapsed_next = e_inc;
                        if (disarm_now) begin
                            disarmed_next      = 1'b1;
                            item_next.throttle = MIN_THROTTLE;
                            item_next.phase    = PH_DISARMED;
                        end else begin
                            item_next.roll  = clamp_corr(s_roll_correction, lim16);
                            item_next.pitch = clamp_corr(s_pitch_correction, lim16);
                            item_next.yaw   = clamp_corr(s_yaw_correction, lim16);
                            if (cnt_inc >= {1'b0, period}) begin
                                item_next.send = 1'b1;
                                send_cnt_next  = 8'd0;
                            end else begin
                                send_cnt_next = cnt_inc[7:0];
                            end
                            if (!in_flight) begin
                                item_next.phase = PH_LANDING;
                                state_next      = ST_RAMP;
                            end
                        end
                    end
                end
            end
            ST_RAMP: begin
                if (ramp_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid || m_ready) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            elapsed_reg  <= 18'd0;
            disarmed_reg <= 1'b1;
            send_cnt_reg <= 8'd0;
        end else begin
            state_reg    <= state_next;
            elapsed_reg  <= elapsed_next;
            disarmed_reg <= disarmed_next;
            send_cnt_reg <= send_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    always_comb begin
        mix_in = item_reg;
        if (item_reg.phase == PH_LANDING) begin
            mix_in.throttle = item_reg.throttle - {1'b0, ramp_quot};
        end
    end

    qxm_mix u_mix (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .load                (load),
        .mix_in              (mix_in),
        .m_ready             (m_ready),
        .m_valid             (m_valid),
        .m_front_right_pulse (m_front_right_pulse),
        .m_rear_right_pulse  (m_rear_right_pulse),
        .m_front_left_pulse  (m_front_left_pulse),
        .m_rear_left_pulse   (m_rear_left_pulse),
        .m_throttle_now      (m_throttle_now),
        .m_phase             (m_phase),
        .m_send_now          (m_send_now)
    );

    a_ramp_done_while_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        ramp_done |-> state_reg == ST_RAMP)
        else $error("Ramp unit finished while the sequencer was not waiting on it.");

    a_disarmed_pulses_minimum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_phase == PH_DISARMED |->
            m_front_right_pulse == MIN_PULSE && m_rear_right_pulse == MIN_PULSE &&
            m_front_left_pulse == MIN_PULSE && m_rear_left_pulse == MIN_PULSE &&
            m_throttle_now == MIN_THROTTLE && !m_send_now)
        else $error("Disarmed result does not hold all motors at minimum.");

    a_pulse_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_front_right_pulse >= MIN_PULSE && m_front_right_pulse <= MAX_PULSE &&
            m_rear_left_pulse >= MIN_PULSE && m_rear_left_pulse <= MAX_PULSE)
        else $error("Motor pulse outside the allowed range.");

    a_landing_throttle_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        load && item_reg.phase == PH_LANDING |->
            mix_in.throttle <= item_reg.throttle && mix_in.throttle > MIN_THROTTLE - 15'd1)
        else $error("Landing throttle left the ramp bounds.");

endmodule

// ===== dv/qxm_tb_pkg.sv =====
// Operation codes shared by the quad-X mixer testbench top and its checker.
// Self-contained; no dependencies.
package qxm_tb_pkg;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

endpackage

// ===== dv/quad_x_mixer_flight_sequencer_checker.sv =====
// Checker for the quad-X mixer: follows register writes, predicts the motor pulses,
// throttle, phase and send strobe of each input transaction, and compares results.
// Depends on qxm_pkg and qxm_tb_pkg.
module quad_x_mixer_flight_sequencer_checker
    import qxm_pkg::*;
    import qxm_tb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_op,
    input  logic signed [15:0] s_roll_correction,
    input  logic signed [15:0] s_pitch_correction,
    input  logic signed [15:0] s_yaw_correction,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [10:0] m_front_right_pulse,
    input  logic [10:0] m_rear_right_pulse,
    input  logic [10:0] m_front_left_pulse,
    input  logic [10:0] m_rear_left_pulse,
    input  logic [14:0] m_throttle_now,
    input  logic [1:0]  m_phase,
    input  logic        m_send_now,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [10:0] fr;
        logic [10:0] rr;
        logic [10:0] fl;
        logic [10:0] rl;
        logic [14:0] thr;
        logic [1:0]  ph;
        logic        snd;
    } motor_result_t;

    logic [10:0] cfg_base;
    logic [10:0] cfg_limit;
    logic [15:0] cfg_flight;
    logic [15:0] cfg_landing;
    logic [7:0]  cfg_period;

    logic [17:0] elapsed;
    logic        disarmed;
    int unsigned send_count;

    motor_result_t pending_mixes[$];
    int fails = 0;

    assign fail_count = fails;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [10:0] pulse_us(input longint sixteenths);
        longint c;
        c = clip(sixteenths, 16 * longint'(MIN_PULSE), 16 * longint'(MAX_PULSE));
        return 11'(c >>> 4);
    endfunction

    function automatic motor_result_t motor_outputs_for(input logic op,
            input logic signed [15:0] roll, input logic signed [15:0] pitch,
            input logic signed [15:0] yaw);
        motor_result_t res;
        longint base, lim, t, r, p, y, lead, span;
        int unsigned period;
        base = clip(longint'(cfg_base), longint'(MIN_PULSE), longint'(MAX_PULSE));
        lim = 16 * longint'(cfg_limit);
        if (op == OP_START) begin
            elapsed = '0;
            disarmed = 1'b0;
            send_count = 0;
            res.fr = pulse_us(16 * base);
            res.rr = res.fr;
            res.fl = res.fr;
            res.rl = res.fr;
            res.thr = 15'(16 * base);
            res.ph = PH_FLIGHT;
            res.snd = 1'b0;
            return res;
        end
        if (elapsed != ELAPSED_MAX) elapsed = elapsed + 18'd1;
        if (disarmed ||
            longint'(elapsed) >= longint'(cfg_flight) + longint'(cfg_landing)) begin
            disarmed = 1'b1;
            res.fr = MIN_PULSE;
            res.rr = MIN_PULSE;
            res.fl = MIN_PULSE;
            res.rl = MIN_PULSE;
            res.thr = MIN_THROTTLE;
            res.ph = PH_DISARMED;
            res.snd = 1'b0;
            return res;
        end
        if (longint'(elapsed) < longint'(cfg_flight)) begin
            t = 16 * base;
            res.ph = PH_FLIGHT;
        end else begin
            lead = longint'(elapsed) - longint'(cfg_flight);
            span = (cfg_landing == 16'd0) ? 1 : longint'(cfg_landing);
            t = 16 * base - ((base - longint'(MIN_PULSE)) * 16 * lead) / span;
            res.ph = PH_LANDING;
        end
        r = clip(longint'(roll), -lim, lim);
        p = clip(longint'(pitch), -lim, lim);
        y = clip(longint'(yaw), -lim, lim);
        period = (cfg_period == 8'd0) ? 1 : 32'(cfg_period);
        send_count++;
        res.snd = 1'b0;
        if (send_count >= period) begin
            res.snd = 1'b1;
            send_count = 0;
        end
        res.fr = pulse_us(t - r - p + y);
        res.rr = pulse_us(t - r + p - y);
        res.fl = pulse_us(t + r - p - y);
        res.rl = pulse_us(t + r + p + y);
        res.thr = 15'(t);
        return res;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        motor_result_t want, got;
        if (!aresetn) begin
            cfg_base = RST_BASE_THROTTLE;
            cfg_limit = RST_CORRECTION_LIMIT;
            cfg_flight = RST_FLIGHT_TICKS;
            cfg_landing = RST_LANDING_TICKS;
            cfg_period = RST_SEND_PERIOD;
            elapsed = '0;
            disarmed = 1'b1;
            send_count = 0;
            pending_mixes.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_BASE_THROTTLE:    cfg_base = pwdata[10:0];
                    REG_CORRECTION_LIMIT: cfg_limit = pwdata[10:0];
                    REG_FLIGHT_TICKS:     cfg_flight = pwdata[15:0];
                    REG_LANDING_TICKS:    cfg_landing = pwdata[15:0];
                    REG_SEND_PERIOD:      cfg_period = pwdata[7:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = {m_front_right_pulse, m_rear_right_pulse, m_front_left_pulse,
                       m_rear_left_pulse, m_throttle_now, m_phase, m_send_now};
                if (pending_mixes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    fails++;
                end else begin
                    want = pending_mixes.pop_front();
                    compare_field("front_right_pulse", 32'(want.fr), 32'(got.fr));
                    compare_field("rear_right_pulse", 32'(want.rr), 32'(got.rr));
                    compare_field("front_left_pulse", 32'(want.fl), 32'(got.fl));
                    compare_field("rear_left_pulse", 32'(want.rl), 32'(got.rl));
                    compare_field("throttle_now", 32'(want.thr), 32'(got.thr));
                    compare_field("phase", 32'(want.ph), 32'(got.ph));
                    compare_field("send_now", 32'(want.snd), 32'(got.snd));
                end
            end
            if (s_valid && s_ready)
                pending_mixes.push_back(motor_outputs_for(s_op, s_roll_correction,
                                                          s_pitch_correction,
                                                          s_yaw_correction));
        end
        pending <= pending_mixes.size();
    end

endmodule

// ===== dv/quad_x_mixer_flight_sequencer_core_tb.sv =====
// Testbench top for the quad-X mixer: drives register writes and control ticks with
// random idling on both channels and prints the verdict from the checker's count.
// Depends on qxm_pkg, qxm_tb_pkg and quad_x_mixer_flight_sequencer_checker.
module quad_x_mixer_flight_sequencer_core_tb;
    import qxm_pkg::*;
    import qxm_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = OP_TICK;
    logic signed [15:0] s_roll_correction = '0;
    logic signed [15:0] s_pitch_correction = '0;
    logic signed [15:0] s_yaw_correction = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [10:0] m_front_right_pulse;
    logic [10:0] m_rear_right_pulse;
    logic [10:0] m_front_left_pulse;
    logic [10:0] m_rear_left_pulse;
    logic [14:0] m_throttle_now;
    logic [1:0]  m_phase;
    logic        m_send_now;

    int fail_count;
    int pending;

    int unsigned gap_odds = 0;
    int unsigned stall_odds = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    logic [10:0] cur_limit = RST_CORRECTION_LIMIT;
    logic [15:0] cur_flight = RST_FLIGHT_TICKS;
    logic [15:0] cur_landing = RST_LANDING_TICKS;

    quad_x_mixer_flight_sequencer_core uut (.*);

    quad_x_mixer_flight_sequencer_checker mixer_check (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left <= $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[quad_x_mixer_flight_sequencer_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value,
                             input int width);
        logic [31:0] word;
        word = value;
        if ($urandom_range(0, 3) == 0) word = word | ($urandom << width);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_config(input logic [10:0] base, input logic [10:0] limit,
                                input logic [15:0] flight, input logic [15:0] landing,
                                input logic [7:0] period);
        apb_write(REG_BASE_THROTTLE, 32'(base), 11);
        apb_write(REG_CORRECTION_LIMIT, 32'(limit), 11);
        apb_write(REG_FLIGHT_TICKS, 32'(flight), 16);
        apb_write(REG_LANDING_TICKS, 32'(landing), 16);
        apb_write(REG_SEND_PERIOD, 32'(period), 8);
        cur_limit = limit;
        cur_flight = flight;
        cur_landing = landing;
    endtask

    task automatic send_item(input logic op, input logic signed [15:0] roll,
                             input logic signed [15:0] pitch,
                             input logic signed [15:0] yaw);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_roll_correction <= roll;
        s_pitch_correction <= pitch;
        s_yaw_correction <= yaw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_corr();
        logic signed [15:0] v;
        case ($urandom_range(0, 5))
            0: v = 16'sh7FFF;
            1: v = 16'sh8000;
            2: begin
                v = 16'(cur_limit * 16 + $urandom_range(0, 40) - 20);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            3: v = 16'($urandom_range(0, 6400) - 3200);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic random_config();
        logic [10:0] base, limit;
        logic [15:0] flight, landing;
        logic [7:0]  period;
        case ($urandom_range(0, 7))
            0: base = '0;
            1: base = 11'h7FF;
            2: base = MIN_PULSE;
            3: base = MAX_PULSE;
            4: base = 11'($urandom);
            default: base = 11'($urandom_range(1000, 2000));
        endcase
        case ($urandom_range(0, 5))
            0: limit = '0;
            1: limit = 11'h7FF;
            2: limit = 11'($urandom);
            default: limit = 11'($urandom_range(1, 400));
        endcase
        case ($urandom_range(0, 7))
            0: flight = '0;
            1: flight = 16'hFFFF;
            2: flight = 16'($urandom);
            default: flight = 16'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 7))
            0: landing = '0;
            1: landing = 16'hFFFF;
            2: landing = 16'($urandom_range(1, 3));
            default: landing = 16'($urandom_range(4, 60));
        endcase
        case ($urandom_range(0, 5))
            0: period = '0;
            1: period = 8'hFF;
            2: period = 8'd1;
            default: period = 8'($urandom_range(2, 12));
        endcase
        write_config(base, limit, flight, landing, period);
    endtask

    task automatic fly_phase(input int count);
        int left, run;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(1'($urandom_range(0, 1)), rand_corr(), rand_corr(), rand_corr());
                left--;
            end else begin
                send_item(OP_START, rand_corr(), rand_corr(), rand_corr());
                left--;
                run = int'(cur_flight) + int'(cur_landing) + $urandom_range(0, 4);
                if (run > left) run = left;
                repeat (run) begin
                    if ($urandom_range(0, 199) == 0) wait_for_results();
                    send_item(($urandom_range(0, 49) == 0) ? OP_START : OP_TICK,
                              rand_corr(), rand_corr(), rand_corr());
                end
                left -= run;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_odds = 4;
        stall_odds = 4;
        send_item(OP_TICK, 16'sh1234, 16'sh0000, 16'shFFFF);
        send_item(OP_START, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_item(OP_TICK, 16'sh7FFF, 16'sh8000, 16'sh0000);
        send_item(OP_TICK, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(OP_TICK, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_TICK, 16'sh0000, 16'sh0000, 16'sh0000);

        wait_for_results();
        write_config(11'h7FF, 11'h7FF, 16'd2, 16'd0, 8'd0);
        send_item(OP_START, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(OP_TICK, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_item(OP_TICK, 16'sh8000, 16'sh7FFF, 16'sh8000);
        send_item(OP_TICK, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);

        wait_for_results();
        write_config(11'd0, 11'd0, 16'd0, 16'd3, 8'd1);
        send_item(OP_START, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_TICK, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_item(OP_TICK, 16'sh0100, 16'shFF00, 16'sh0001);
        send_item(OP_TICK, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(OP_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(OP_START, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(OP_TICK, 16'sh0010, 16'shFFF0, 16'sh0000);

        wait_for_results();
        write_config(MAX_PULSE, 11'd1, 16'd1, 16'hFFFF, 8'hFF);
        send_item(OP_START, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(OP_TICK, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_TICK, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(OP_TICK, 16'sh000F, 16'shFFF1, 16'sh0011);

        wait_for_results();
        write_config(MIN_PULSE, 11'd400, 16'hFFFF, 16'd1, 8'd20);
        send_item(OP_START, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(OP_TICK, 16'sh1900, 16'shE700, 16'sh7FFF);
        send_item(OP_TICK, 16'sh8000, 16'sh1000, 16'sh0000);

        for (int phase_idx = 0; phase_idx < 10; phase_idx++) begin
            wait_for_results();
            random_config();
            if (phase_idx >= 8) begin
                gap_odds = 0;
                stall_odds = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: gap_odds = 0;
                    1: gap_odds = 3;
                    default: gap_odds = 8;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_odds = 0;
                    1: stall_odds = 3;
                    default: stall_odds = 8;
                endcase
            end
            fly_phase(123);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("[quad_x_mixer_flight_sequencer_core] OK");
        end else begin
            $display("[quad_x_mixer_flight_sequencer_core] ERROR");
        end
        $finish;
    end

endmodule
